// ===== design/quantile_clip_contrast_scaler_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef QUANTILE_CLIP_CONTRAST_SCALER_UNIT_MACROS_SVH
`define QUANTILE_CLIP_CONTRAST_SCALER_UNIT_MACROS_SVH

// checked outside reset only
`define QCCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define QCCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/qccs_pkg.sv =====
package qccs_pkg;
  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int FRAC_BITS = 16;
  localparam int PROB_W = FRAC_BITS + 1;
  localparam int CUT_W = SAMPLE_BITS + FRAC_BITS;
  localparam int BIT_W = $clog2(SAMPLE_BITS);
  localparam logic [FRAC_BITS-1:0] TOP_FRACTION_RESET = 16'd3277;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

// ===== design/qccs_divider.sv =====
// one quotient bit per cycle: floor(clip * mult / cut), clip <= cut, cut != 0
module qccs_divider (
  input  logic                                    clk,
  input  logic                                    rst,
  input  qccs_pkg::div_ctrl_t                     ctrl,
  input  logic [qccs_pkg::CUT_W-1:0]              clip,
  input  logic [qccs_pkg::SAMPLE_BITS-1:0]        mult,
  input  logic [qccs_pkg::CUT_W-1:0]              cut,
  output qccs_pkg::div_stat_t                     stat,
  output logic [qccs_pkg::SAMPLE_BITS-1:0]        quot
);
  logic [qccs_pkg::CUT_W-1:0]       rem, rem_next, t1, gap1, gap2;
  logic [qccs_pkg::SAMPLE_BITS-1:0] quot_next;
  logic [qccs_pkg::BIT_W-1:0]       bitpos;
  logic                             busy, done, c1, c2;

  always_comb begin
    gap1 = cut - rem;
    c1   = (rem >= gap1);
    t1   = c1 ? (rem - gap1) : (rem + rem);
    gap2 = cut - clip;
    c2   = mult[bitpos] && (t1 >= gap2);
    if (!mult[bitpos]) begin
      rem_next = t1;
    end else if (c2) begin
      rem_next = t1 - gap2;
    end else begin
      rem_next = t1 + clip;
    end
    quot_next = {quot[qccs_pkg::SAMPLE_BITS-2:0], 1'b0}
              + qccs_pkg::SAMPLE_BITS'(c1) + qccs_pkg::SAMPLE_BITS'(c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitpos <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        bitpos <= qccs_pkg::BIT_W'(qccs_pkg::SAMPLE_BITS - 1);
        rem    <= '0;
        quot   <= '0;
      end else if (busy) begin
        rem    <= rem_next;
        quot   <= quot_next;
        bitpos <= bitpos - 1'b1;
        if (bitpos == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// ===== design/quantile_clip_contrast_scaler_unit.sv =====
// channel  | dir | tdata             | tlast    | tuser
// s_*      | in  | sample [31:0]     | last     | -
// m_*      | out | scaled [31:0]     | last_res | -
// cfg_*    | in  | top_fraction[15:0]| -        | -
// loading an item steps through ST_SORTRD and ST_SORTCP for each stored entry it moves past,
// then ST_CHECK (a full store skips the sort); s_tready is low meanwhile
// on the flagged item ST_RDA to ST_ADD build the cutoff; each result takes ST_EMITRD, ST_START,
// the 32-step bit-serial divider (skipped for a zero cutoff) and any stall on m_tready
// rst is synchronous; count, running maximum and control clear, stores do not
module quantile_clip_contrast_scaler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // scaled
  output logic        m_tlast,   // last_res
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata  // top_fraction
);
  localparam int SB = qccs_pkg::SAMPLE_BITS;
  localparam int IW = qccs_pkg::IDX_W;
  localparam int CW = qccs_pkg::CNT_W;
  localparam int FB = qccs_pkg::FRAC_BITS;
  localparam int XW = qccs_pkg::CUT_W;
  localparam int PW = qccs_pkg::IDX_W + qccs_pkg::PROB_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SORTRD = 4'd1;
  localparam logic [3:0] ST_SORTCP = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_RDA    = 4'd4;
  localparam logic [3:0] ST_RDB    = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_ADD    = 4'd7;
  localparam logic [3:0] ST_EMITRD = 4'd8;
  localparam logic [3:0] ST_START  = 4'd9;
  localparam logic [3:0] ST_DIV    = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  logic [SB-1:0] sample_mem [qccs_pkg::MAX_SAMPLES];
  logic [SB-1:0] sorted_mem [qccs_pkg::MAX_SAMPLES];
  logic [SB-1:0] sample_rd, sorted_rd;

  logic [3:0]    state;
  logic [15:0]   top_fraction;
  logic [CW-1:0] count, ins_pos, emit_idx;
  logic [SB-1:0] run_max, cur, val_a;
  logic          cur_last;
  logic [IW-1:0] lo;
  logic [FB-1:0] hfrac;
  logic [XW-1:0] prod, cut, clip;
  logic [qccs_pkg::PROB_W-1:0] prob;
  logic [PW-1:0] pos;
  logic [CW-1:0] lo_next;
  logic [XW-1:0] shifted;

  qccs_pkg::div_ctrl_t div_ctrl;
  qccs_pkg::div_stat_t div_stat;
  logic [SB-1:0]       div_q;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign prob     = qccs_pkg::PROB_W'(17'h10000) - qccs_pkg::PROB_W'(top_fraction);
  assign pos      = PW'(IW'(count - 1'b1)) * PW'(prob);
  assign lo_next  = {1'b0, lo} + 1'b1;
  assign shifted  = {sample_rd, FB'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      top_fraction <= qccs_pkg::TOP_FRACTION_RESET;
    end else if (cfg_we) begin
      top_fraction <= cfg_wdata;
    end
  end

  // sample store: write on accept while not full, read during emission
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && count < CW'(qccs_pkg::MAX_SAMPLES)) begin
      sample_mem[count[IW-1:0]] <= s_tdata;
    end
    sample_rd <= sample_mem[emit_idx[IW-1:0]];
  end

  // sorted store: at most one read and one write per cycle
  always_ff @(posedge clk) begin
    if (state == ST_SORTRD && ins_pos == '0) begin
      sorted_mem[0] <= cur;
    end else if (state == ST_SORTCP) begin
      sorted_mem[ins_pos[IW-1:0]] <= (sorted_rd > cur) ? sorted_rd : cur;
    end
    unique case (state)
      ST_SORTRD: sorted_rd <= sorted_mem[IW'(ins_pos - 1'b1)];
      ST_RDA:    sorted_rd <= sorted_mem[lo];
      ST_RDB:    sorted_rd <= sorted_mem[lo_next[IW-1:0]];
      default:   sorted_rd <= sorted_rd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      run_max  <= '0;
      m_tvalid <= 1'b0;
      emit_idx <= '0;
      ins_pos  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur      <= s_tdata;
            cur_last <= s_tlast;
            ins_pos  <= count;
            if (count < CW'(qccs_pkg::MAX_SAMPLES)) begin
              if (s_tdata > run_max) begin
                run_max <= s_tdata;
              end
              state <= ST_SORTRD;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_SORTRD: begin
          if (ins_pos == '0) begin
            count <= count + 1'b1;
            state <= ST_CHECK;
          end else begin
            state <= ST_SORTCP;
          end
        end
        ST_SORTCP: begin
          if (sorted_rd > cur) begin
            ins_pos <= ins_pos - 1'b1;
            state   <= ST_SORTRD;
          end else begin
            count <= count + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          lo    <= pos[FB+IW-1:FB];
          hfrac <= pos[FB-1:0];
          if (!cur_last || count == '0) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_RDA;
          end
        end
        ST_RDA: state <= ST_RDB;
        ST_RDB: begin
          val_a <= sorted_rd;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (hfrac != '0 && lo_next < count && sorted_rd != val_a) begin
            prod <= XW'(hfrac) * XW'(sorted_rd - val_a);
          end else begin
            prod <= '0;
          end
          emit_idx <= '0;
          state    <= ST_ADD;
        end
        ST_ADD: begin
          cut   <= {val_a, FB'(0)} + prod;
          state <= ST_EMITRD;
        end
        ST_EMITRD: state <= ST_START;
        ST_START: begin
          clip <= (shifted > cut) ? cut : shifted;
          if (cut == '0) begin
            m_tdata  <= '0;
            m_tlast  <= (emit_idx == count - 1'b1);
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            m_tdata  <= div_q;
            m_tlast  <= (emit_idx == count - 1'b1);
            m_tvalid <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (emit_idx == count - 1'b1) begin
              count   <= '0;
              run_max <= '0;
              state   <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= ST_EMITRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // start pulse registered on the same edge as clip, only for a nonzero cut
  logic div_go;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b0;
    end else begin
      div_go <= (state == ST_START) && (cut != '0);
    end
  end
  assign div_ctrl.start = div_go;

  qccs_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .clip (clip),
    .mult (run_max),
    .cut  (cut),
    .stat (div_stat),
    .quot (div_q)
  );
endmodule

// ===== design/qccs_checker.sv =====
`include "quantile_clip_contrast_scaler_unit_macros.svh"

module qccs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata
);
  `QCCS_ASSERT(a_out_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped while stalled")
  `QCCS_ASSERT(a_no_overlap, m_tvalid |-> !s_tready, "input taken during emission")
  `QCCS_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready stayed high after an item")
  `QCCS_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result valid after reset")
endmodule

bind quantile_clip_contrast_scaler_unit qccs_checker u_qccs_checker (.*);
